/* rtl/rws_pkg.sv */
// shared types and constants for the roulette wheel selector
package rws_pkg;

  localparam int MAX_ENTRIES_DEF  = 256;
  localparam int FITNESS_BITS_DEF = 32;
  localparam int RND_BITS         = 32;
  localparam int INDEX_OUT_BITS   = 8;
  localparam int STATUS_BITS      = 2;
  localparam int MODE_BITS        = 2;

  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_LOAD   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_SELECT = 2'd2;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_WALK
  } state_t;

endpackage

/* rtl/rws_ram.sv */
// generic single-port-write, registered-read ram
module rws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/rws_sub_unit.sv */
// shared subtract and compare unit
module rws_sub_unit #(
  parameter int WIDTH = 41
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             ge
);

  logic [WIDTH:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[WIDTH-1:0];
  assign ge   = ~full[WIDTH];

endmodule

/* rtl/roulette_wheel_selector.sv */
// roulette wheel selector top level: population store, sequencer and result register
//
// Clear gives no result. A load's result strobes on out_valid in the cycle after the
// transfer. A select reduces random_word modulo the running total one bit per cycle
// through the shared subtractor, then walks the stored fitness values in load order at
// one entry per cycle, reading the store through its registered port; the result
// strobes in the cycle after the chosen entry is found. An empty population or zero
// total answers at once, without raising busy. busy is high while a select reduces
// and walks. The
// result is present for exactly one cycle and is not held: the receiver must take it.
module roulette_wheel_selector #(
  parameter int MAX_ENTRIES  = rws_pkg::MAX_ENTRIES_DEF,
  parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rws_pkg::MODE_BITS-1:0]       in_mode,
  input  logic [31:0]                         in_fitness,
  input  logic [rws_pkg::RND_BITS-1:0]        in_random_word,
  output logic                                out_valid,
  output logic [rws_pkg::INDEX_OUT_BITS-1:0]  out_chosen_index,
  output logic [rws_pkg::STATUS_BITS-1:0]     out_status
);

  localparam int IDXW = $clog2(MAX_ENTRIES);
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int TW   = FITNESS_BITS + IDXW;
  localparam int UW   = TW + 1;
  localparam int BCW  = $clog2(rws_pkg::RND_BITS);

  rws_pkg::state_t state_r, state_nxt;

  logic [CNTW-1:0]                    count_r, count_nxt;
  logic [TW-1:0]                      total_r, total_nxt;
  logic [TW-1:0]                      rem_r, rem_nxt;
  logic [rws_pkg::RND_BITS-1:0]       rnd_r, rnd_nxt;
  logic [BCW-1:0]                     bit_r, bit_nxt;
  logic [IDXW-1:0]                    idx_r, idx_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [rws_pkg::INDEX_OUT_BITS-1:0] out_idx_r, out_idx_nxt;
  logic [rws_pkg::STATUS_BITS-1:0]    out_status_r, out_status_nxt;

  logic                    accept;
  logic                    full;
  logic [FITNESS_BITS-1:0] fit_w;
  logic                    wr_en;
  logic [IDXW-1:0]         rd_addr;
  logic [FITNESS_BITS-1:0] rd_data;
  logic [UW-1:0]           op_a, op_b, diff;
  logic                    ge;
  logic                    last_entry;

  assign accept     = start && (state_r == rws_pkg::ST_IDLE);
  assign full       = (count_r == CNTW'(MAX_ENTRIES));
  assign fit_w      = FITNESS_BITS'(in_fitness);
  assign wr_en      = accept && (in_mode == rws_pkg::MODE_LOAD) && !full;
  assign rd_addr    = (state_r == rws_pkg::ST_WALK) ? idx_r + IDXW'(1) : '0;
  assign last_entry = (CNTW'(idx_r) == count_r - CNTW'(1));

  rws_ram #(
    .WIDTH (FITNESS_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDXW-1:0]),
    .wr_data (fit_w),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rws_sub_unit #(
    .WIDTH (UW)
  ) u_sub (
    .a    (op_a),
    .b    (op_b),
    .diff (diff),
    .ge   (ge)
  );

  // operand selection for the shared unit
  always_comb begin
    case (state_r)
      rws_pkg::ST_MOD: begin
        op_a = {rem_r, rnd_r[rws_pkg::RND_BITS-1]};
        op_b = UW'(total_r);
      end
      rws_pkg::ST_WALK: begin
        op_a = UW'(rem_r);
        op_b = UW'(rd_data);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rws_pkg::ST_IDLE: begin
        if (accept && (in_mode == rws_pkg::MODE_SELECT) &&
            (count_r != '0) && (total_r != '0)) begin
          state_nxt = rws_pkg::ST_MOD;
        end
      end
      rws_pkg::ST_MOD: begin
        if (bit_r == '0) begin
          state_nxt = rws_pkg::ST_WALK;
        end
      end
      rws_pkg::ST_WALK: begin
        if (!ge || last_entry) begin
          state_nxt = rws_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rws_pkg::ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    count_nxt      = count_r;
    total_nxt      = total_r;
    rem_nxt        = rem_r;
    rnd_nxt        = rnd_r;
    bit_nxt        = bit_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;
    case (state_r)
      rws_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            rws_pkg::MODE_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
            end
            rws_pkg::MODE_LOAD: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_idx_nxt    = '0;
                out_status_nxt = rws_pkg::STATUS_FULL;
              end else begin
                out_idx_nxt    = rws_pkg::INDEX_OUT_BITS'(count_r);
                out_status_nxt = rws_pkg::STATUS_OK;
                count_nxt      = count_r + CNTW'(1);
                total_nxt      = total_r + TW'(fit_w);
              end
            end
            rws_pkg::MODE_SELECT: begin
              if ((count_r == '0) || (total_r == '0)) begin
                out_valid_nxt  = 1'b1;
                out_idx_nxt    = '0;
                out_status_nxt = rws_pkg::STATUS_EMPTY;
              end else begin
                rem_nxt = '0;
                rnd_nxt = in_random_word;
                bit_nxt = BCW'(rws_pkg::RND_BITS - 1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      rws_pkg::ST_MOD: begin
        // restoring modulo, one bit per cycle
        rem_nxt = ge ? diff[TW-1:0] : op_a[TW-1:0];
        rnd_nxt = {rnd_r[rws_pkg::RND_BITS-2:0], 1'b0};
        bit_nxt = bit_r - BCW'(1);
        idx_nxt = '0;
      end
      rws_pkg::ST_WALK: begin
        if (!ge) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = rws_pkg::INDEX_OUT_BITS'(idx_r);
          out_status_nxt = rws_pkg::STATUS_OK;
        end else if (last_entry) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = '0;
          out_status_nxt = rws_pkg::STATUS_EMPTY;
        end else begin
          rem_nxt = diff[TW-1:0];
          idx_nxt = idx_r + IDXW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rws_pkg::ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r        <= rem_nxt;
    rnd_r        <= rnd_nxt;
    bit_r        <= bit_nxt;
    idx_r        <= idx_nxt;
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy             = (state_r != rws_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_idx_r;
  assign out_status       = out_status_r;

endmodule
